// ===== sv/pal_pkg.sv =====
// Shared types and constants for the positional array list.
package pal_pkg;

  // Storage geometry.
  localparam int CAPACITY    = 128;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 8;
  localparam int POS_W       = 8;
  localparam int GROUP_SIZE  = 8;
  localparam int NUM_GROUPS  = CAPACITY / GROUP_SIZE;

  // Capacity register reset value, also used when the register holds zero.
  localparam logic [CNT_W-1:0] LIMIT_DEFAULT = CNT_W'(100);

  typedef enum logic [1:0] {
    MODE_READ    = 2'd0,
    MODE_REPLACE = 2'd1,
    MODE_INSERT  = 2'd2,
    MODE_DELETE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Controls for one storage cell.
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
    logic rd_sel;
  } cell_ctl_t;

  // Command broadcast from the controller to the cell row.
  typedef struct packed {
    logic              vld;
    mode_e             op;
    logic [IDX_W-1:0]  p0;
    logic [DATA_W-1:0] wval;
  } cmd_t;

endpackage

// ===== sv/pal_cell.sv =====
// One storage cell of the list: holds a single entry and trades it with its neighbors.
module pal_cell
  import pal_pkg::*;
(
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic [DATA_W-1:0] wval_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] value_o,
  output logic [DATA_W-1:0] rd_o
);

  logic [DATA_W-1:0] value_q, value_d;

  // Next entry: new value, lower neighbor on insert, upper neighbor on delete.
  always_comb begin
    value_d = value_q;
    if (ctl_i.load) begin
      value_d = wval_i;
    end else if (ctl_i.take_left) begin
      value_d = left_i;
    end else if (ctl_i.take_right) begin
      value_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // Only the addressed cell drives the read tree.
  assign rd_o    = ctl_i.rd_sel ? value_q : '0;

endmodule

// ===== sv/pal_ctrl.sv =====
// Controller: operation checks, entry count, capacity register and result registers.
module pal_ctrl
  import pal_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        mode_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] wval_i,
  input  logic              cfg_valid_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  input  logic [DATA_W-1:0] rd_word_i,
  output cmd_t              cmd_o,
  output logic              busy_o,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [DATA_W-1:0] read_value_o,
  output logic [CNT_W-1:0]  list_length_o,
  output logic              is_empty_o,
  output logic              is_full_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cfg_q;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] count_nx;
  logic [POS_W-1:0] pos_m1;
  logic             in_rng, ins_rng, op_ok;
  mode_e            mode;
  status_e          status;

  logic             s1_vld_q;
  status_e          s1_status_q;
  logic [CNT_W-1:0] s1_count_q;
  logic             s1_empty_q, s1_full_q, s1_rd_ok_q;

  logic              done_q;
  status_e           status_q;
  logic [DATA_W-1:0] rval_q;
  logic [CNT_W-1:0]  len_q;
  logic              empty_q, full_q;

  // Effective capacity: zero means the default, larger values clip to the storage size.
  always_comb begin
    lim = cfg_q;
    if (cfg_q == '0) begin
      lim = LIMIT_DEFAULT;
    end
    if (lim > CNT_W'(CAPACITY)) begin
      lim = CNT_W'(CAPACITY);
    end
  end

  // Range checks on the requested position.
  assign mode    = mode_e'(mode_i);
  assign in_rng  = (position_i != '0) && (position_i <= count_q);
  assign ins_rng = (position_i != '0) &&
                   ({1'b0, position_i} <= ({1'b0, count_q} + (CNT_W+1)'(1)));

  // Status decode for the incoming operation.
  always_comb begin
    unique case (mode) inside
      MODE_READ, MODE_REPLACE: begin
        status = in_rng ? ST_OK : ST_BAD_POS;
      end
      MODE_INSERT: begin
        status = (count_q >= lim) ? ST_FULL : (ins_rng ? ST_OK : ST_BAD_POS);
      end
      MODE_DELETE: begin
        status = (count_q == '0) ? ST_EMPTY : (in_rng ? ST_OK : ST_BAD_POS);
      end
      default: begin
        status = ST_BAD_POS;
      end
    endcase
  end

  assign op_ok = (status == ST_OK);

  // Count after the operation.
  always_comb begin
    count_nx = count_q;
    if (op_ok && (mode == MODE_INSERT)) begin
      count_nx = count_q + CNT_W'(1);
    end else if (op_ok && (mode == MODE_DELETE)) begin
      count_nx = count_q - CNT_W'(1);
    end
  end

  assign count_d = accept_i ? count_nx : count_q;

  // Command to the cell row; applied at the accepting edge.
  assign pos_m1     = position_i - POS_W'(1);
  assign cmd_o.vld  = accept_i && op_ok;
  assign cmd_o.op   = mode;
  assign cmd_o.p0   = pos_m1[IDX_W-1:0];
  assign cmd_o.wval = wval_i;

  // Count and capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cfg_q   <= LIMIT_DEFAULT;
    end else begin
      count_q <= count_d;
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  // First stage: decision of the accepted transaction while the read tree settles.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_status_q <= status;
      s1_count_q  <= count_nx;
      s1_empty_q  <= (count_nx == '0);
      s1_full_q   <= (count_nx >= lim);
      s1_rd_ok_q  <= op_ok && (mode == MODE_READ);
    end
  end

  // Result registers; the strobe lasts one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      status_q <= s1_status_q;
      rval_q   <= s1_rd_ok_q ? rd_word_i : '0;
      len_q    <= s1_count_q;
      empty_q  <= s1_empty_q;
      full_q   <= s1_full_q;
    end
  end

  assign busy_o        = s1_vld_q;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_value_o  = rval_q;
  assign list_length_o = len_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;

  // The count never exceeds the storage size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above storage size");

  // Every accepted transaction yields a result strobe after the first stage.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> ##1 done_o)
    else $error("result strobe missing");

  // A successful insert grows the count by one.
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && op_ok && (mode == MODE_INSERT)) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the count");

  // A failed transaction returns zero data.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (read_value_o == '0))
    else $error("failed transaction returned data");

  // No new transaction while one is in the first stage.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> !accept_i)
    else $error("overlapping transactions");

endmodule

// ===== sv/positional_array_list_unit.sv =====
// Top level of the positional array list: controller, cell row and registered read tree.
//
//   channel   | direction | handshake                    | payload
//   ----------+-----------+------------------------------+------------------------------------
//   command   | in        | start high while busy low    | mode_i, position_i, write_value_i
//   result    | out       | done_o, one cycle, no stall  | status_o, read_value_o,
//             |           |                              | list_length_o, is_empty_o, is_full_o
//   capacity  | in        | cfg_valid_i and cfg_ready_o  | cfg_data_i
//
// In a transaction the cell row shifts or writes at the accepting edge while
// eight-cell groups of the read tree capture the addressed entry; the next edge combines the
// groups into the result registers and raises done_o.
// busy is high while the first stage holds a transaction, so no new transaction enters
// then. Reset clears the count and sets the capacity to 100; entries need no clearing.
// The receiver cannot stall; cfg_ready_o is always high.
module positional_array_list_unit
  import pal_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] write_value_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [CNT_W-1:0]         list_length_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CNT_W-1:0]         cfg_data_i
);

  logic              accept;
  cmd_t              cmd;
  logic [DATA_W-1:0] value [CAPACITY];
  logic [DATA_W-1:0] rd    [CAPACITY];
  logic [DATA_W-1:0] group_d [NUM_GROUPS];
  logic [DATA_W-1:0] group_q [NUM_GROUPS];
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] rval;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  pal_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode_i),
    .position_i   (position_i),
    .wval_i       (write_value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .rd_word_i    (rd_word),
    .cmd_o        (cmd),
    .busy_o       (busy),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (rval),
    .list_length_o(list_length_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  assign read_value_o = rval;

  // Row of cells; each decodes its role from the broadcast command.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t         ctl;
    logic [DATA_W-1:0] left, right;

    assign ctl.load       = cmd.vld && (cmd.p0 == IDX_W'(i)) &&
                            ((cmd.op == MODE_REPLACE) || (cmd.op == MODE_INSERT));
    assign ctl.take_left  = cmd.vld && (cmd.op == MODE_INSERT) && (cmd.p0 < IDX_W'(i));
    assign ctl.take_right = cmd.vld && (cmd.op == MODE_DELETE) && (cmd.p0 <= IDX_W'(i));
    assign ctl.rd_sel     = (cmd.p0 == IDX_W'(i));

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = value[i+1];
    end

    pal_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .wval_i (cmd.wval),
      .left_i (left),
      .right_i(right),
      .value_o(value[i]),
      .rd_o   (rd[i])
    );
  end

  // First level of the read tree: one register per group of cells.
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    always_comb begin
      group_d[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        group_d[g] = group_d[g] | rd[g*GROUP_SIZE + j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (accept) begin
        group_q[g] <= group_d[g];
      end
    end
  end

  // Second level: combine the group registers.
  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      rd_word = rd_word | group_q[g];
    end
  end

endmodule
